[hdl/lr_pkg.sv]
// Shared constants and types for the line rasterizer.
package lr_pkg;

  // Width of one coordinate
  localparam int unsigned COORD_BITS = 6;
  // Width of the color word
  localparam int unsigned COLOR_BITS = 16;
  // Error term: signed, it spans minus to plus the major span
  localparam int unsigned ERR_BITS   = COORD_BITS + 2;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_WALK  = 3'b100
  } lr_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture a new request
    logic setup;  // orient the line and seed the walk
    logic step;   // emit one pixel and advance
  } lr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic at_end;     // current pixel is the last of the line
    logic out_valid;  // output register holds a pixel
  } lr_status_t;

endpackage

[hdl/lr_ctrl.sv]
// Controller state machine for the line rasterizer.
module lr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               out_stall_i,
  input  lr_pkg::lr_status_t status_i,
  output lr_pkg::lr_cmd_t    cmd_o
);
  import lr_pkg::*;

  lr_state_e state_q, state_d;
  logic      out_free;

  // Output slot is free when empty or being taken this cycle
  assign out_free = !status_i.out_valid || !out_stall_i;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cmd_o.load  = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.setup = (state_q == ST_SETUP);
  assign cmd_o.step  = (state_q == ST_WALK) && out_free;

  // Advance through capture, setup and pixel walk
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (cmd_o.step && status_i.at_end) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/lr_datapath.sv]
// Datapath for the line rasterizer: endpoint registers, error walk, output register.
module lr_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lr_pkg::lr_cmd_t    cmd_i,
  output lr_pkg::lr_status_t status_o,
  input  lr_pkg::coord_t     start_x_i,
  input  lr_pkg::coord_t     start_y_i,
  input  lr_pkg::coord_t     end_x_i,
  input  lr_pkg::coord_t     end_y_i,
  input  lr_pkg::color_t     line_color_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output lr_pkg::coord_t     pixel_x_o,
  output lr_pkg::coord_t     pixel_y_o,
  output lr_pkg::color_t     pixel_color_o,
  output logic               last_pixel_o
);
  import lr_pkg::*;

  // Captured request
  coord_t ax_q, ay_q, bx_q, by_q;
  color_t color_q;

  // Walk state
  logic   steep_q;
  logic   dir_neg_q;
  coord_t major_q, end_q, minor_q, span_q, rise_q;
  err_t   err_q;

  // Output register
  logic   out_valid_q;
  coord_t px_q, py_q;
  color_t pc_q;
  logic   last_q;

  // Setup terms
  coord_t adx, ady, sax, say, sbx, sby, lo_maj, lo_min, hi_maj, hi_min, span_s, rise_s;
  logic   steep, swap;

  // Walk terms
  err_t   err_sub;
  logic   at_end;

  // Orient the line: exchange axes when steep, order by major coordinate
  always_comb begin
    adx    = (bx_q > ax_q) ? (bx_q - ax_q) : (ax_q - bx_q);
    ady    = (by_q > ay_q) ? (by_q - ay_q) : (ay_q - by_q);
    steep  = ady > adx;
    sax    = steep ? ay_q : ax_q;
    say    = steep ? ax_q : ay_q;
    sbx    = steep ? by_q : bx_q;
    sby    = steep ? bx_q : by_q;
    swap   = sax > sbx;
    lo_maj = swap ? sbx : sax;
    lo_min = swap ? sby : say;
    hi_maj = swap ? sax : sbx;
    hi_min = swap ? say : sby;
    span_s = hi_maj - lo_maj;
    rise_s = (hi_min > lo_min) ? (hi_min - lo_min) : (lo_min - hi_min);
  end

  assign err_sub = err_q - err_t'({2'b00, rise_q});
  assign at_end  = (major_q == end_q);

  assign status_o.at_end    = at_end;
  assign status_o.out_valid = out_valid_q;

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q    <= start_x_i;
      ay_q    <= start_y_i;
      bx_q    <= end_x_i;
      by_q    <= end_y_i;
      color_q <= line_color_i;
    end
  end

  // Seed and advance the walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      steep_q   <= steep;
      major_q   <= lo_maj;
      end_q     <= hi_maj;
      minor_q   <= lo_min;
      span_q    <= span_s;
      rise_q    <= rise_s;
      err_q     <= err_t'({2'b00, span_s >> 1});
      dir_neg_q <= lo_min > hi_min;
    end else if (cmd_i.step) begin
      major_q <= major_q + coord_t'(1);
      if (err_sub < 0) begin
        err_q   <= err_sub + err_t'({2'b00, span_q});
        minor_q <= dir_neg_q ? (minor_q - coord_t'(1)) : (minor_q + coord_t'(1));
      end else begin
        err_q <= err_sub;
      end
    end
  end

  // Load the output register on each step
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      px_q   <= steep_q ? minor_q : major_q;
      py_q   <= steep_q ? major_q : minor_q;
      pc_q   <= color_q;
      last_q <= at_end;
    end
  end

  // Hold the pixel until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = pc_q;
  assign last_pixel_o  = last_q;

endmodule

[hdl/line_rasterizer_unit.sv]
// Top level of the line rasterizer: controller, datapath and checks.
//
//  Channel  Direction  Handshake               Payload
//  in       input      in_valid_i / in_stall_o  start_x_i start_y_i end_x_i end_y_i line_color_i
//  out      output     out_valid_o / out_stall_i pixel_x_o pixel_y_o pixel_color_o last_pixel_o
//
// A line of major span N gives N + 1 pixels: the block captures the request,
// orients the line, then emits one pixel per cycle from the error-term walk while the output is not stalled.
// Reset clears the controller and the output valid only.
// A stall on the output holds the walk; the last pixel may wait while the next
// request is taken.
module line_rasterizer_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lr_pkg::coord_t start_x_i,
  input  lr_pkg::coord_t start_y_i,
  input  lr_pkg::coord_t end_x_i,
  input  lr_pkg::coord_t end_y_i,
  input  lr_pkg::color_t line_color_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lr_pkg::coord_t pixel_x_o,
  output lr_pkg::coord_t pixel_y_o,
  output lr_pkg::color_t pixel_color_o,
  output logic           last_pixel_o
);
  import lr_pkg::*;

  lr_cmd_t    cmd;
  lr_status_t status;

  lr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lr_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .line_color_i  (line_color_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_pixel_o  (last_pixel_o)
  );

  // An accepted request closes the input until the line is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after a request");

  // A step never overwrites a pixel still waiting downstream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> (!out_valid_o || !out_stall_i))
    else $error("step overwrote a stalled pixel");

  // Stepping the last pixel reopens the input and flags the result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.step && status.at_end) |=> (!in_stall_o && out_valid_o && last_pixel_o))
    else $error("line end not handled");

endmodule

[tb/line_rasterizer_unit_tb.sv]
// Self-checking testbench for the line rasterizer: drives lines, checks every pixel.
`timescale 1ns / 1ps

module line_rasterizer_unit_tb;
  import lr_pkg::*;

  // Cycles without any handshake before the run is declared hung
  localparam int unsigned HANG_LIMIT = 4000;
  // Cycles to let the block settle after the last expected pixel
  localparam int unsigned DRAIN_CYCLES = 70;
  // Receiver hold-off used to back the block up into its input
  localparam int unsigned HOLD_OFF_CYCLES = 500;
  localparam int unsigned PHASE_ITEMS = 80;
  localparam int unsigned PRESSURE_ITEMS = 40;
  localparam int unsigned MAX_COORD = (1 << COORD_BITS) - 1;

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } pixel_t;

  // Expected pixel store with its own Bresenham predictor
  class pixel_scoreboard;
    pixel_t pending_pixels[$];
    int unsigned errors;

    // Print one line per mismatch, for the first 100 only, and count every mismatch
    task report(input string msg);
      if (errors < 100) $display("ERROR: %s (t=%0t)", msg, $time);
      errors++;
    endtask

    // Walk the line the way the block does and queue every pixel
    function void trace_line(input coord_t sx, input coord_t sy,
                             input coord_t ex, input coord_t ey, input color_t color);
      int ax, ay, bx, by, tmp;
      int adx, ady, span, rise, err, dir, minor;
      bit steep;
      pixel_t px;
      ax = sx; ay = sy; bx = ex; by = ey;
      adx = (bx > ax) ? bx - ax : ax - bx;
      ady = (by > ay) ? by - ay : ay - by;
      steep = ady > adx;
      // Exchange axes for steep lines
      if (steep) begin
        tmp = ax; ax = ay; ay = tmp;
        tmp = bx; bx = by; by = tmp;
      end
      // Order endpoints so the major coordinate rises
      if (ax > bx) begin
        tmp = ax; ax = bx; bx = tmp;
        tmp = ay; ay = by; by = tmp;
      end
      span = bx - ax;
      rise = (by > ay) ? by - ay : ay - by;
      err = span / 2;
      dir = (ay < by) ? 1 : -1;
      minor = ay;
      for (int major = ax; major <= bx; major++) begin
        px.x = steep ? coord_t'(minor) : coord_t'(major);
        px.y = steep ? coord_t'(major) : coord_t'(minor);
        px.color = color;
        px.last = (major == bx);
        pending_pixels.push_back(px);
        err -= rise;
        if (err < 0) begin
          minor += dir;
          err += span;
        end
      end
    endfunction

    // Compare one emitted pixel against the oldest expectation
    task check_pixel(input pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("unexpected pixel x=%0d y=%0d", got.x, got.y));
      end else begin
        want = pending_pixels.pop_front();
        if (got.x !== want.x)
          report($sformatf("pixel_x got %0d want %0d", got.x, want.x));
        if (got.y !== want.y)
          report($sformatf("pixel_y got %0d want %0d", got.y, want.y));
        if (got.color !== want.color)
          report($sformatf("pixel_color got %h want %h", got.color, want.color));
        if (got.last !== want.last)
          report($sformatf("last_pixel got %b want %b at x=%0d y=%0d",
                           got.last, want.last, want.x, want.y));
      end
    endtask
  endclass

  logic   clk_i = 1'b0;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_stall_o;
  coord_t start_x_i;
  coord_t start_y_i;
  coord_t end_x_i;
  coord_t end_y_i;
  color_t line_color_i;
  logic   out_valid_o;
  logic   out_stall_i = 1'b0;
  coord_t pixel_x_o;
  coord_t pixel_y_o;
  color_t pixel_color_o;
  logic   last_pixel_o;

  pixel_scoreboard sb = new();
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_off;
  int unsigned quiet_cycles = 0;

  line_rasterizer_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .line_color_i (line_color_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .pixel_color_o(pixel_color_o),
    .last_pixel_o (last_pixel_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the output at random, or hold it off completely under pressure
  always @(negedge clk_i) begin
    if (hold_off) out_stall_i = 1'b1;
    else out_stall_i = ($urandom_range(99) < recv_stall_pct);
  end

  // Check each accepted pixel
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_pixel('{x: pixel_x_o, y: pixel_y_o, color: pixel_color_o,
                       last: last_pixel_o});
  end

  // Abort when no handshake happens for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles == HANG_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // Offer one line request and hold it until the block takes it
  task automatic draw_line(input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey, input color_t color);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    start_x_i = sx;
    start_y_i = sy;
    end_x_i = ex;
    end_y_i = ey;
    line_color_i = color;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.trace_line(sx, sy, ex, ey, color);
  endtask

  // Place a span of the given length at random, in random direction
  function automatic void place_span(input int unsigned span,
                                     output coord_t a, output coord_t b);
    int unsigned lo;
    lo = $urandom_range(MAX_COORD - span);
    if ($urandom_range(1)) begin
      a = coord_t'(lo);
      b = coord_t'(lo + span);
    end else begin
      a = coord_t'(lo + span);
      b = coord_t'(lo);
    end
  endfunction

  // Draw a random line, biased toward the special shapes
  task automatic draw_random_line();
    coord_t sx, sy, ex, ey;
    int unsigned dx, dy, dm;
    dx = $urandom_range(MAX_COORD);
    dy = $urandom_range(MAX_COORD);
    case ($urandom_range(9))
      0: begin dx = 0; dy = 0; end
      1: dy = 0;
      2: dx = 0;
      3: dy = dx;
      4: begin dx = $urandom_range(3); dy = $urandom_range(3); end
      5: begin
        dm = $urandom_range(2);
        dy = (dx > dm) ? dx - dm : dx;
      end
      default: ;
    endcase
    place_span(dx, sx, ex);
    place_span(dy, sy, ey);
    draw_line(sx, sy, ex, ey, color_t'($urandom()));
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    start_x_i = '0;
    start_y_i = '0;
    end_x_i = '0;
    end_y_i = '0;
    line_color_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: single pixels, full-range axis lines, diagonals, both endpoint orders
    draw_line(0, 0, 0, 0, 16'h0000);
    draw_line(63, 63, 63, 63, 16'hFFFF);
    draw_line(0, 0, 63, 0, 16'hF800);
    draw_line(63, 0, 0, 0, 16'h07E0);
    draw_line(0, 0, 0, 63, 16'h001F);
    draw_line(0, 63, 0, 0, 16'hFFFF);
    draw_line(0, 0, 63, 63, 16'h5555);
    draw_line(63, 0, 0, 63, 16'hAAAA);
    draw_line(0, 63, 63, 0, 16'h0001);
    draw_line(63, 63, 0, 0, 16'h8000);
    draw_line(0, 0, 63, 1, 16'h1234);
    draw_line(1, 0, 0, 63, 16'hFEDC);
    draw_line(10, 20, 40, 5, 16'h0F0F);
    draw_line(40, 5, 10, 20, 16'hF0F0);
    draw_line(5, 10, 20, 40, 16'h3C3C);
    draw_line(20, 40, 5, 10, 16'hC3C3);
    draw_line(3, 7, 4, 9, 16'h7FFF);
    draw_line(0, 0, 1, 1, 16'hFFFE);
    draw_line(62, 1, 2, 61, 16'h00FF);
    draw_line(30, 30, 31, 30, 16'hFF00);

    // Random lines under each idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      repeat (PHASE_ITEMS) draw_random_line();
    end

    // Back the block up: hold the output off while requests keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off = 1'b0;
      end
      repeat (PRESSURE_ITEMS) draw_random_line();
    join

    // Drop valid and drain
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
